FILE: sv/iuc_pkg.sv
package iuc_pkg;

   // field widths of the transaction payloads
   localparam int FIELD_ID_W = 50;
   localparam int TOTAL_W    = 51;
   localparam int COUNT_W    = 9;
   localparam int STATUS_W   = 2;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd2;

   typedef struct packed {
      logic [FIELD_ID_W-1:0] range_start;
      logic [FIELD_ID_W-1:0] range_end;
   } iuc_req_type;

   typedef struct packed {
      logic [TOTAL_W-1:0]  covered_total;
      logic [COUNT_W-1:0]  range_count;
      logic [STATUS_W-1:0] status;
   } iuc_rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_FINISH,
      ST_REPORT
   } iuc_state_type;

   // status from the datapath to the sequencer
   typedef struct packed {
      logic req_fire;
      logic range_bad;
      logic rsp_free;
   } iuc_stat_type;

   // strobes from the sequencer to the datapath
   typedef struct packed {
      logic req_ready;
      logic clearing;
      logic rd_issue;
      logic commit;
      logic report;
   } iuc_ctrl_type;

endpackage

FILE: sv/interval_union_coverage.sv
// a range with start after end goes straight to the report step; any other range is first
// scanned against the entry memory, then merged and stored in the finish step, then reported
// a new range is taken only in the idle state, after the last result has been registered;
// the scan reads one entry per cycle through the single read port of the entry memory
// reset: a clearing pass over all MAX_RANGES entries zeroes the entry memory, req_ready stays low
module interval_union_coverage
   import iuc_pkg::*;
#(
   parameter int MAX_RANGES = 256,
   parameter int ID_WIDTH   = 50
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  iuc_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output iuc_rsp_type rsp_data
);

   localparam int AW     = $clog2(MAX_RANGES);
   localparam int CNT_W  = $clog2(MAX_RANGES + 1);
   localparam int WORD_W = 2 * ID_WIDTH + 1;
   localparam int TOT_W  = ID_WIDTH + 1;

   iuc_stat_type stat;
   iuc_ctrl_type ctrl;
   logic [AW-1:0] addr;

   logic [ID_WIDTH-1:0] req_lo, req_hi;
   logic                req_fire;

   // captured range and merge accumulators
   logic [ID_WIDTH-1:0] lo_in_ff, hi_in_ff;
   logic [ID_WIDTH-1:0] mlo_ff, mhi_ff;
   logic [TOT_W-1:0]    absorbed_ff;
   logic [CNT_W-1:0]    removed_ff;
   logic                found_ff;
   logic                free_found_ff;
   logic [AW-1:0]       free_ff;

   logic          proc_vld_ff;
   logic [AW-1:0] proc_idx_ff;

   logic [TOT_W-1:0]    total_ff;
   logic [CNT_W-1:0]    count_ff;
   logic [STATUS_W-1:0] status_ff;
   logic                rsp_valid_ff;
   iuc_rsp_type         rsp_data_ff;

   logic [WORD_W-1:0]   rd_data;
   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   logic [WORD_W-1:0]   wr_data;

   logic                e_vld;
   logic [ID_WIDTH-1:0] e_start, e_end;
   logic                overlap;
   logic                take_free;
   logic                table_full;
   logic                rsp_free;

   assign req_lo   = ID_WIDTH'(req_data.range_start);
   assign req_hi   = ID_WIDTH'(req_data.range_end);
   assign req_fire = req_valid && ctrl.req_ready;
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   assign stat.req_fire  = req_fire;
   assign stat.range_bad = (req_lo > req_hi);
   assign stat.rsp_free  = rsp_free;

   iuc_ctrl #(
      .MAX_RANGES(MAX_RANGES)
   ) u_ctrl (
      .clock(clock),
      .reset(reset),
      .stat (stat),
      .ctrl (ctrl),
      .addr (addr)
   );

   iuc_ram #(
      .WIDTH(WORD_W),
      .DEPTH(MAX_RANGES)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (ctrl.rd_issue),
      .rd_addr(addr),
      .rd_data(rd_data)
   );

   // unpack the entry that came back from memory
   assign e_vld   = rd_data[WORD_W-1];
   assign e_start = rd_data[WORD_W-2 -: ID_WIDTH];
   assign e_end   = rd_data[ID_WIDTH-1:0];

   // stored ranges are disjoint, so testing against the new range alone is enough
   assign overlap    = proc_vld_ff && e_vld && !(hi_in_ff < e_start) && !(e_end < lo_in_ff);
   assign take_free  = proc_vld_ff && (!e_vld || overlap) && !free_found_ff;
   assign table_full = !found_ff && !free_found_ff;

   // memory write: clearing pass, dropping absorbed entries, storing the merged range
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = addr;
      wr_data = '0;
      priority if (ctrl.clearing) begin
         wr_en = 1'b1;
      end else if (overlap) begin
         wr_en   = 1'b1;
         wr_addr = proc_idx_ff;
      end else if (ctrl.commit && !table_full) begin
         wr_en   = 1'b1;
         wr_addr = free_ff;
         wr_data = {1'b1, mlo_ff, mhi_ff};
      end
   end

   // read pipeline tracking
   always_ff @(posedge clock) begin
      if (reset) begin
         proc_vld_ff <= 1'b0;
      end else begin
         proc_vld_ff <= ctrl.rd_issue;
      end
      proc_idx_ff <= addr;
   end

   // merge accumulators over the scan
   always_ff @(posedge clock) begin
      if (req_fire) begin
         lo_in_ff      <= req_lo;
         hi_in_ff      <= req_hi;
         mlo_ff        <= req_lo;
         mhi_ff        <= req_hi;
         absorbed_ff   <= '0;
         removed_ff    <= '0;
         found_ff      <= 1'b0;
         free_found_ff <= 1'b0;
      end else begin
         if (overlap) begin
            if (e_start < mlo_ff) mlo_ff <= e_start;
            if (e_end > mhi_ff)   mhi_ff <= e_end;
            absorbed_ff <= absorbed_ff + {1'b0, e_end - e_start} + TOT_W'(1);
            removed_ff  <= removed_ff + CNT_W'(1);
            found_ff    <= 1'b1;
         end
         if (take_free) begin
            free_ff       <= proc_idx_ff;
            free_found_ff <= 1'b1;
         end
      end
   end

   // running total, range count and status
   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff  <= '0;
         count_ff  <= '0;
         status_ff <= STATUS_OK;
      end else begin
         if (req_fire) begin
            status_ff <= stat.range_bad ? STATUS_INVALID : STATUS_OK;
         end else if (ctrl.commit) begin
            if (table_full) begin
               status_ff <= STATUS_FULL;
            end else begin
               total_ff <= total_ff - absorbed_ff + {1'b0, mhi_ff - mlo_ff} + TOT_W'(1);
               count_ff <= count_ff - removed_ff + CNT_W'(1);
            end
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.report && rsp_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (ctrl.report && rsp_free) begin
         rsp_data_ff.covered_total <= TOTAL_W'(total_ff);
         rsp_data_ff.range_count   <= COUNT_W'(count_ff);
         rsp_data_ff.status        <= status_ff;
      end
   end

   assign req_ready = ctrl.req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a new result only follows the report step
   a_rsp_from_report: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(ctrl.report))
      else $error("result raised outside the report step");

   // stored range count never exceeds the table depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_RANGES))
      else $error("range count beyond table depth");

   // the merged range is written only into a slot found free in the scan
   a_commit_slot: assert property (@(posedge clock) disable iff (reset)
      (ctrl.commit && wr_en) |-> free_found_ff)
      else $error("merged range stored without a free slot");

   // no transaction is taken while the memory is being cleared
   a_clear_block: assert property (@(posedge clock) disable iff (reset)
      ctrl.clearing |-> !req_ready)
      else $error("request taken during the clearing pass");

endmodule

FILE: sv/iuc_ram.sv
module iuc_ram
   import iuc_pkg::*;
#(
   parameter int WIDTH = 101,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // single write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/iuc_ctrl.sv
module iuc_ctrl
   import iuc_pkg::*;
#(
   parameter int MAX_RANGES = 256
) (
   input  logic                          clock,
   input  logic                          reset,
   input  iuc_stat_type                  stat,
   output iuc_ctrl_type                  ctrl,
   output logic [$clog2(MAX_RANGES)-1:0] addr
);

   localparam int CNT_W = $clog2(MAX_RANGES + 1);

   iuc_state_type    state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             cnt_last;
   logic             cnt_end;

   assign cnt_last = (cnt_ff == CNT_W'(MAX_RANGES - 1));
   assign cnt_end  = (cnt_ff == CNT_W'(MAX_RANGES));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (cnt_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (stat.req_fire) state_in = stat.range_bad ? ST_REPORT : ST_SCAN;
         end
         ST_SCAN: begin
            if (cnt_end) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            state_in = ST_REPORT;
         end
         ST_REPORT: begin
            if (stat.rsp_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // entry counter for the clearing pass and the scan
   always_comb begin
      unique case (state_ff)
         ST_CLEAR: cnt_in = cnt_ff + CNT_W'(1);
         ST_SCAN:  cnt_in = cnt_end ? cnt_ff : cnt_ff + CNT_W'(1);
         default:  cnt_in = '0;
      endcase
   end

   // strobes
   always_comb begin
      ctrl           = '0;
      ctrl.req_ready = (state_ff == ST_IDLE);
      ctrl.clearing  = (state_ff == ST_CLEAR);
      ctrl.rd_issue  = (state_ff == ST_SCAN) && !cnt_end;
      ctrl.commit    = (state_ff == ST_FINISH);
      ctrl.report    = (state_ff == ST_REPORT);
   end

   assign addr = cnt_ff[$clog2(MAX_RANGES)-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule
